>>> sv/ssrp_pkg.sv
package ssrp_pkg;

    // Field widths fixed by the interface
    localparam int ACCEL_W   = 24;
    localparam int ELAPSED_W = 16;
    localparam int TARGET_W  = 17;
    localparam int COUNT_W   = 32;
    localparam int SINCE_W   = 32;
    localparam int DELTA_W   = ACCEL_W + ELAPSED_W;

    // Interval test only multiplies when since_last_step < 1e6 < 2^20
    localparam int RATE_BITS = 20;
    localparam int CNT_W     = 5;

    localparam int                    SPEED_INT_MAX = 65535;
    localparam logic [RATE_BITS-1:0]  US_PER_SEC    = 20'd1000000;

    // Request kinds
    typedef enum logic [1:0] {
        CMD_TICK        = 2'd0,
        CMD_SET_TARGET  = 2'd1,
        CMD_CLEAR_COUNT = 2'd2
    } t_cmd;

    // Configuration register indexes
    localparam logic CFG_ACCEL_RATE = 1'b0;
    localparam logic CFG_INVERT     = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCEL,
        S_RAMP,
        S_CHECK,
        S_RATE,
        S_FIRE,
        S_DONE
    } t_state;

endpackage

>>> sv/stepper_speed_ramp_pulser.sv
// Stepper speed ramp and step pulse scheduler.
// Input channel (i_valid / o_ready) carries one request: a time tick with
// i_elapsed_us, a new signed target speed, or a clear of the step count.
// Output channel (o_valid / i_ready) returns exactly one result per request:
// step pulse flag, direction, enable, moving, step count and current speed.
// Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) writes accel_rate
// (index 0) and invert_direction (index 1); write only while idle.
// Sequence: a tick while moving runs the bit-serial accel_rate x elapsed
// multiplier, then ramp, check, the bit-serial since_last_step x |speed|
// interval multiplier, update and output load. The interval multiply is
// skipped when the last step is at least 1e6 us old or the speed is below
// one step per second. Other requests go straight to output load. One
// request is in flight at a time and the next is taken the cycle after the
// result loads.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls, the following result holds in
// the block until the output register frees up.
// Reset (synchronous, active low) clears speed, target, moving flag and
// step count, saturates the time since the last step, and empties the
// output register.
module stepper_speed_ramp_pulser #(
    parameter int SPEED_FRAC_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic                                    i_cfg_idx,
    input  logic [ssrp_pkg::ACCEL_W-1:0]            i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [1:0]                              i_cmd,
    input  logic [ssrp_pkg::ELAPSED_W-1:0]          i_elapsed_us,
    input  logic signed [ssrp_pkg::TARGET_W-1:0]    i_target_speed,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic                                    o_step_pulse,
    output logic                                    o_direction,
    output logic                                    o_enable,
    output logic                                    o_moving,
    output logic signed [ssrp_pkg::COUNT_W-1:0]     o_step_count,
    output logic signed [ssrp_pkg::TARGET_W-1:0]    o_current_speed
);
    import ssrp_pkg::*;

    localparam int F  = SPEED_FRAC_BITS;
    localparam int SW = 17 + F;
    localparam int MW = SW - 1;
    localparam int WW = ((DELTA_W > MW) ? DELTA_W : MW) + 2;
    localparam int PW = RATE_BITS + MW;
    localparam logic [WW-1:0] LIM_W   = WW'(SPEED_INT_MAX) << F;
    localparam logic [PW-1:0] THRESH  = PW'(US_PER_SEC) << F;
    localparam logic [CNT_W-1:0] ACCEL_LAST = CNT_W'(ELAPSED_W - 1);
    localparam logic [CNT_W-1:0] RATE_LAST  = CNT_W'(RATE_BITS - 1);

    t_state r_state, n_state;

    // Configuration
    logic [ACCEL_W-1:0]     r_accel;
    logic                   r_invert;

    // Motor state
    logic signed [SW-1:0]   r_speed;
    logic signed [SW-1:0]   r_goal;
    logic                   r_run;
    logic [SINCE_W-1:0]     r_since;
    logic [COUNT_W-1:0]     r_count;

    // Serial datapath
    logic [CNT_W-1:0]       r_cnt;
    logic [RATE_BITS-1:0]   r_mplier;
    logic [DELTA_W-1:0]     r_dcand;
    logic [DELTA_W-1:0]     r_delta;
    logic [PW-1:0]          r_pcand;
    logic [PW-1:0]          r_prod;
    logic [MW-1:0]          r_mag;
    logic                   r_fire;
    logic                   r_pulse;

    // Output register
    logic                   r_o_valid;
    logic                   r_o_pulse;
    logic                   r_o_dir;
    logic                   r_o_run;
    logic [COUNT_W-1:0]     r_o_count;
    logic [TARGET_W-1:0]    r_o_speed;

    // Control strobes
    logic                   w_accept;
    logic                   w_load_out;

    // Combinational datapath
    logic signed [17:0]     w_tgt;
    logic signed [17:0]     w_tgt_neg;
    logic signed [17:0]     w_tgt_clamp;
    logic [SINCE_W:0]       w_since_sum;
    logic signed [SW-1:0]   w_speed_abs;
    logic [MW-1:0]          w_mag;
    logic [15:0]            w_int;
    logic                   w_mag_ge_one;
    logic                   w_since_big;
    logic signed [WW-1:0]   w_spd_x;
    logic signed [WW-1:0]   w_goal_x;
    logic signed [WW-1:0]   w_delta_x;
    logic signed [WW-1:0]   w_gap;
    logic signed [WW-1:0]   w_gap_abs;
    logic signed [WW-1:0]   w_up;
    logic signed [WW-1:0]   w_dn;
    logic signed [WW-1:0]   w_new;
    logic                   w_fire;
    logic                   w_fwd;

    // Negate (when invert_direction is set) and clamp the commanded target
    always_comb begin
        w_tgt     = {i_target_speed[TARGET_W-1], i_target_speed};
        w_tgt_neg = r_invert ? -w_tgt : w_tgt;
        if (w_tgt_neg > 18'sd65535) begin
            w_tgt_clamp = 18'sd65535;
        end else if (w_tgt_neg < -18'sd65535) begin
            w_tgt_clamp = -18'sd65535;
        end else begin
            w_tgt_clamp = w_tgt_neg;
        end
    end

    assign w_since_sum  = {1'b0, r_since} + (SINCE_W + 1)'(i_elapsed_us);

    // Speed magnitude and integer part
    assign w_speed_abs  = r_speed[SW-1] ? -r_speed : r_speed;
    assign w_mag        = w_speed_abs[MW-1:0];
    assign w_int        = w_mag[MW-1:F];
    assign w_mag_ge_one = |w_mag[MW-1:F];
    assign w_since_big  = (r_since >= SINCE_W'(US_PER_SEC));

    // Move the speed toward the goal by delta, snap or clamp
    always_comb begin
        w_spd_x   = {{(WW-SW){r_speed[SW-1]}}, r_speed};
        w_goal_x  = {{(WW-SW){r_goal[SW-1]}}, r_goal};
        w_delta_x = {{(WW-DELTA_W){1'b0}}, r_delta};
        w_gap     = w_spd_x - w_goal_x;
        w_gap_abs = w_gap[WW-1] ? -w_gap : w_gap;
        w_up      = w_spd_x + w_delta_x;
        w_dn      = w_spd_x - w_delta_x;
        if (w_gap_abs < w_delta_x) begin
            w_new = w_goal_x;
        end else if (w_spd_x < w_goal_x) begin
            w_new = (w_up > $signed(LIM_W)) ? $signed(LIM_W) : w_up;
        end else if (w_spd_x > w_goal_x) begin
            w_new = (w_dn < -$signed(LIM_W)) ? -$signed(LIM_W) : w_dn;
        end else begin
            w_new = w_spd_x;
        end
    end

    // Step decision from the interval test
    assign w_fire = r_fire || (|r_mag[MW-1:F] && (r_prod >= THRESH));
    assign w_fwd  = (!r_speed[SW-1]) != r_invert;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if ((i_cmd == CMD_TICK) && r_run) begin
                        n_state = S_ACCEL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ACCEL: begin
                if (r_cnt == ACCEL_LAST) begin
                    n_state = S_RAMP;
                end
            end
            S_RAMP:  n_state = S_CHECK;
            S_CHECK: begin
                if (w_since_big || !w_mag_ge_one) begin
                    n_state = S_FIRE;
                end else begin
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                if (r_cnt == RATE_LAST) begin
                    n_state = S_FIRE;
                end
            end
            S_FIRE:  n_state = S_DONE;
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake strobes
    always_comb begin
        o_ready    = (r_state == S_IDLE);
        w_accept   = (r_state == S_IDLE) && i_valid;
        w_load_out = (r_state == S_DONE) && (!r_o_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel  <= '0;
            r_invert <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACCEL_RATE: r_accel  <= i_cfg_data;
                CFG_INVERT:     r_invert <= i_cfg_data[0];
                default:        r_invert <= r_invert;
            endcase
        end
    end

    // Motor state and serial multipliers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_goal  <= '0;
            r_run   <= 1'b0;
            r_since <= '1;
            r_count <= '0;
            r_pulse <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pulse  <= 1'b0;
                        r_cnt    <= '0;
                        r_delta  <= '0;
                        r_dcand  <= DELTA_W'(r_accel);
                        r_mplier <= RATE_BITS'(i_elapsed_us);
                        case (i_cmd)
                            CMD_TICK: begin
                                r_since <= w_since_sum[SINCE_W] ? '1
                                                                : w_since_sum[SINCE_W-1:0];
                            end
                            CMD_SET_TARGET: begin
                                r_goal <= {w_tgt_clamp[16:0], {F{1'b0}}};
                                r_run  <= (w_tgt_clamp != 18'sd0);
                            end
                            CMD_CLEAR_COUNT: begin
                                r_count <= '0;
                            end
                            default: begin
                                r_count <= r_count;
                            end
                        endcase
                    end
                end
                S_ACCEL: begin
                    // accumulate accel_rate x elapsed, one multiplier bit a cycle
                    if (r_mplier[0]) begin
                        r_delta <= r_delta + r_dcand;
                    end
                    r_dcand  <= r_dcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 1'b1;
                end
                S_RAMP: begin
                    r_speed <= w_new[SW-1:0];
                end
                S_CHECK: begin
                    r_mag    <= w_mag;
                    r_fire   <= w_since_big;
                    r_prod   <= '0;
                    r_pcand  <= PW'(w_mag);
                    r_mplier <= r_since[RATE_BITS-1:0];
                    r_cnt    <= '0;
                end
                S_RATE: begin
                    // accumulate since_last_step x |speed|, one bit a cycle
                    if (r_mplier[0]) begin
                        r_prod <= r_prod + r_pcand;
                    end
                    r_pcand  <= r_pcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 1'b1;
                end
                S_FIRE: begin
                    if (w_fire) begin
                        r_pulse <= 1'b1;
                        r_since <= '0;
                        r_count <= w_fwd ? r_count + 1'b1 : r_count - 1'b1;
                    end
                    if ((r_goal == '0) && !(|r_mag[MW-1:F])) begin
                        r_run <= 1'b0;
                    end
                end
                default: begin
                    r_pulse <= r_pulse;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_pulse <= r_pulse;
            r_o_dir   <= !r_speed[SW-1];
            r_o_run   <= r_run;
            r_o_count <= r_count;
            r_o_speed <= r_speed[SW-1] ? -{1'b0, w_int} : {1'b0, w_int};
        end
    end

    assign o_valid         = r_o_valid;
    assign o_step_pulse    = r_o_pulse;
    assign o_direction     = r_o_dir;
    assign o_enable        = r_o_run;
    assign o_moving        = r_o_run;
    assign o_step_count    = r_o_count;
    assign o_current_speed = r_o_speed;

    // The ramp only runs while the motor is moving
    a_accel_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACCEL) |-> r_run)
        else $error("ramp multiplier active while not moving");

    // A step restarts the interval timer
    a_fire_clears_since: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIRE) && w_fire) |=> (r_since == '0))
        else $error("step fired without clearing the interval timer");

    // Speed stays within the saturation limit
    a_speed_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WW'(w_mag) <= LIM_W))
        else $error("speed magnitude beyond limit");

    // A result is loaded only when the output register is free or draining
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_ready) |-> !w_load_out)
        else $error("pending result overwritten");

    // An accepted request leaves the idle state
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("request accepted but not processed");

endmodule
